// ===== rtl/pli_pkg.sv =====
// Package for the positional list block: operation codes, status codes,
// cell control codes and the control word broadcast to the cell chain.
// No dependencies.
package pli_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int MODE_W       = 3;
  localparam int POS_W        = 6;
  localparam int STAT_W       = 2;
  localparam int LEN_OUT_W    = 6;
  // cell index width, wide enough for the largest supported capacity (64)
  localparam int IDX_W        = 6;

  // input modes
  localparam logic [MODE_W-1:0] MODE_INS_FIRST = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_LAST  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEL_FIRST = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEL_LAST  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DEL_POS   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_DUMP      = 3'd6;
  localparam logic [MODE_W-1:0] MODE_COUNT     = 3'd7;

  // result status
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  // cell operations
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;
  localparam logic [1:0] CELL_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
  } pli_ctl_t;

endpackage

// ===== rtl/pli_if.sv =====
// Valid/ready channel interfaces for the positional list block:
// one for input words, one for result words. No dependencies.
interface pli_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] value;
  logic [5:0]         position;

  modport source (output valid, mode, value, position, input ready);
  modport sink   (input valid, mode, value, position, output ready);
endinterface

interface pli_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] element;
  logic               element_valid;
  logic [5:0]         length;
  logic               last;

  modport source (output valid, status, element, element_valid, length, last, input ready);
  modport sink   (input valid, status, element, element_valid, length, last, output ready);
endinterface

// ===== rtl/pli_cell.sv =====
// One storage cell of the list chain. Takes its value from the insert bus,
// a neighbor or the chain head as the broadcast control word says.
// Depends on pli_pkg.
module pli_cell #(
  parameter logic [pli_pkg::IDX_W-1:0] CELL_ID = '0
) (
  input  logic                              clk,
  input  pli_pkg::pli_ctl_t                 ctl,
  input  logic signed [pli_pkg::DATA_W-1:0] ins_val,
  input  logic signed [pli_pkg::DATA_W-1:0] left_val,
  input  logic signed [pli_pkg::DATA_W-1:0] right_val,
  input  logic signed [pli_pkg::DATA_W-1:0] head_val,
  output logic signed [pli_pkg::DATA_W-1:0] data
);
  import pli_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_INS: begin
        if (CELL_ID == ctl.idx) begin
          data_nxt = ins_val;
        end else if (CELL_ID > ctl.idx) begin
          data_nxt = left_val;
        end
      end
      CELL_DEL: begin
        if (CELL_ID >= ctl.idx) begin
          data_nxt = right_val;
        end
      end
      CELL_ROT: begin
        // idx marks the tail; the head wraps around to it
        if (CELL_ID == ctl.idx) begin
          data_nxt = head_val;
        end else if (CELL_ID < ctl.idx) begin
          data_nxt = right_val;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== rtl/pli_ctrl.sv =====
// Control for the positional list: decodes input words, tracks the length,
// steers the cell chain and holds the result register.
// Depends on pli_pkg and the channel interfaces in pli_if.sv.
module pli_ctrl #(
  parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pli_in_if.sink                            in_ch,
  pli_out_if.source                         out_ch,
  input  logic signed [pli_pkg::DATA_W-1:0] head_val,
  output pli_pkg::pli_ctl_t                 ctl,
  output logic signed [pli_pkg::DATA_W-1:0] ins_val
);
  import pli_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

  localparam logic S_RUN  = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic          state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;

  logic                     ov_r, ov_nxt;
  logic [STAT_W-1:0]        os_r, os_nxt;
  logic signed [DATA_W-1:0] oe_r, oe_nxt;
  logic                     oev_r, oev_nxt;
  logic [LEN_OUT_W-1:0]     ol_r, ol_nxt;
  logic                     olast_r, olast_nxt;

  logic          out_free, acc;
  logic [CW-1:0] len_ext, pos_ext;
  logic          full, empty, pos_zero;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  tail_idx;

  assign out_free    = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_RUN) && out_free;
  assign acc         = in_ch.valid && in_ch.ready;

  assign len_ext  = CW'(len_r);
  assign pos_ext  = CW'(in_ch.position);
  assign full     = len_ext >= CW'(CAPACITY);
  assign empty    = (len_r == '0);
  assign pos_zero = (in_ch.position == '0);
  assign tail_idx = IDX_W'(len_ext - CW'(1));
  assign ins_val  = in_ch.value;

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    ctl.op    = CELL_HOLD;
    ctl.idx   = '0;
    status    = ST_OK;
    ov_nxt    = ov_r && !out_ch.ready;
    os_nxt    = os_r;
    oe_nxt    = oe_r;
    oev_nxt   = oev_r;
    ol_nxt    = ol_r;
    olast_nxt = olast_r;

    if (acc) begin
      case (in_ch.mode)
        MODE_INS_FIRST, MODE_INS_LAST, MODE_INS_POS: begin
          if (full) begin
            status = ST_FULL;
          end else if (in_ch.mode == MODE_INS_POS &&
                       (pos_zero || pos_ext > len_ext + CW'(1))) begin
            status = ST_BADPOS;
          end else begin
            ctl.op  = CELL_INS;
            ctl.idx = (in_ch.mode == MODE_INS_FIRST) ? '0 :
                      (in_ch.mode == MODE_INS_LAST)  ? IDX_W'(len_ext) :
                      IDX_W'(in_ch.position - POS_W'(1));
            len_nxt = LW'(len_ext + CW'(1));
          end
        end
        MODE_DEL_FIRST, MODE_DEL_LAST, MODE_DEL_POS: begin
          if (empty) begin
            status = ST_EMPTY;
          end else if (in_ch.mode == MODE_DEL_POS &&
                       (pos_zero || pos_ext > len_ext)) begin
            status = ST_BADPOS;
          end else begin
            ctl.op  = CELL_DEL;
            ctl.idx = (in_ch.mode == MODE_DEL_FIRST) ? '0 :
                      (in_ch.mode == MODE_DEL_LAST)  ? tail_idx :
                      IDX_W'(in_ch.position - POS_W'(1));
            len_nxt = LW'(len_ext - CW'(1));
          end
        end
        default: status = ST_OK;
      endcase

      if (in_ch.mode == MODE_DUMP && !empty) begin
        // enter the dump state, which streams the elements
        state_nxt = S_DUMP;
        cnt_nxt   = '0;
      end else begin
        ov_nxt    = 1'b1;
        os_nxt    = status;
        oe_nxt    = '0;
        oev_nxt   = 1'b0;
        ol_nxt    = LEN_OUT_W'(len_nxt);
        olast_nxt = 1'b1;
      end
    end else if (state_r == S_DUMP && out_free) begin
      // emit the head, rotate it to the tail
      ctl.op    = CELL_ROT;
      ctl.idx   = tail_idx;
      ov_nxt    = 1'b1;
      os_nxt    = ST_OK;
      oe_nxt    = head_val;
      oev_nxt   = 1'b1;
      ol_nxt    = len_ext[LEN_OUT_W-1:0];
      olast_nxt = (CW'(cnt_r) + CW'(1) == len_ext);
      cnt_nxt   = LW'(CW'(cnt_r) + CW'(1));
      if (olast_nxt) begin
        state_nxt = S_RUN;
        cnt_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      len_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    os_r    <= os_nxt;
    oe_r    <= oe_nxt;
    oev_r   <= oev_nxt;
    ol_r    <= ol_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.status        = os_r;
  assign out_ch.element       = oe_r;
  assign out_ch.element_valid = oev_r;
  assign out_ch.length        = ol_r;
  assign out_ch.last          = olast_r;

endmodule

// ===== rtl/positional_list_insert_delete.sv =====
// Positional list: a bounded ordered list of CAPACITY signed 32-bit values held
// in a chain of cells. Insert and delete (front, back or 1-based position)
// shift the whole chain at once, and a new word, these or a count query, is
// taken every cycle while the result register can drain. A dump streams one
// element a cycle while the result register can drain, read from the head
// cell while the chain rotates; no input word is taken until the last element
// has moved into the result register. An empty dump yields one result with
// element_valid low. Every result carries the length after the operation,
// modulo 64. Depends on pli_pkg, pli_if, pli_cell and pli_ctrl.
module positional_list_insert_delete #(
  parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pli_in_if.sink    in_ch,
  pli_out_if.source out_ch
);
  import pli_pkg::*;

  pli_ctl_t                 ctl;
  logic signed [DATA_W-1:0] ins_val;
  logic signed [DATA_W-1:0] cell_q [CAPACITY];

  pli_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .head_val (cell_q[0]),
    .ctl      (ctl),
    .ins_val  (ins_val)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_val;
    logic signed [DATA_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_left
      assign left_val = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_right
      assign right_val = cell_q[i+1];
    end

    pli_cell #(
      .CELL_ID(IDX_W'(i))
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .ins_val   (ins_val),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (cell_q[0]),
      .data      (cell_q[i])
    );
  end

endmodule

// ===== rtl/pli_checker.sv =====
// Port-level checks for the positional list, bound to the top level.
// Depends on pli_pkg and positional_list_insert_delete.
module pli_checker #(
  parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_element,
  input logic        out_element_valid,
  input logic [5:0]  out_length,
  input logic        out_last
);
  import pli_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_element) &&
      $stable(out_status) && $stable(out_last) && $stable(out_length))
    else $error("result word changed while stalled");

  a_elem_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_element_valid |-> out_status == ST_OK)
    else $error("stored element with a failing status");

  a_nonelem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_element_valid |-> out_element == '0 && out_last)
    else $error("non-element result not zero or not last");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_length == 6'(CAPACITY))
    else $error("full status with wrong length");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_length == '0)
    else $error("empty status with nonzero length");

endmodule

bind positional_list_insert_delete pli_checker #(
  .CAPACITY(CAPACITY)
) u_pli_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_element       (out_ch.element),
  .out_element_valid (out_ch.element_valid),
  .out_length        (out_ch.length),
  .out_last          (out_ch.last)
);

// ===== bench/pli_list_mirror_pkg.sv =====
// Scoreboard for the positional list bench: a mirror of the list contents
// and the queue of result words it predicts. Depends on pli_pkg.
package pli_list_mirror_pkg;
  import pli_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] element;
    logic                     element_valid;
    logic [LEN_OUT_W-1:0]     length;
    logic                     last;
  } list_result_t;

  class list_mirror;
    logic signed [DATA_W-1:0] cells[$];
    list_result_t             pending_results[$];
    int unsigned              mismatches;
    int unsigned              capacity;

    function new(int unsigned cap);
      capacity   = cap;
      mismatches = 0;
    endfunction

    function int unsigned count();
      return cells.size();
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function void push_result(logic [STAT_W-1:0] status, logic signed [DATA_W-1:0] element,
                              logic element_valid, logic last);
      list_result_t r;
      r.status        = status;
      r.element       = element;
      r.element_valid = element_valid;
      r.length        = LEN_OUT_W'(cells.size());
      r.last          = last;
      pending_results.push_back(r);
    endfunction

    // Apply one accepted input word to the mirror and queue its results.
    function void note_word(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] value,
                            logic [POS_W-1:0] position);
      logic [STAT_W-1:0] status;
      int unsigned       len;
      len    = cells.size();
      status = ST_OK;
      case (mode)
        MODE_INS_FIRST, MODE_INS_LAST, MODE_INS_POS: begin
          // full check wins over the position check
          if (len >= capacity) begin
            status = ST_FULL;
          end else if (mode == MODE_INS_FIRST) begin
            cells.push_front(value);
          end else if (mode == MODE_INS_LAST) begin
            cells.push_back(value);
          end else if (position < 1 || position > len + 1) begin
            status = ST_BADPOS;
          end else begin
            cells.insert(int'(position) - 1, value);
          end
        end
        MODE_DEL_FIRST, MODE_DEL_LAST, MODE_DEL_POS: begin
          if (len == 0) begin
            status = ST_EMPTY;
          end else if (mode == MODE_DEL_FIRST) begin
            void'(cells.pop_front());
          end else if (mode == MODE_DEL_LAST) begin
            void'(cells.pop_back());
          end else if (position < 1 || position > len) begin
            status = ST_BADPOS;
          end else begin
            cells.delete(int'(position) - 1);
          end
        end
        MODE_DUMP: begin
          if (len != 0) begin
            foreach (cells[i]) begin
              push_result(ST_OK, cells[i], 1'b1, i == cells.size() - 1);
            end
            return;
          end
        end
        default: begin
        end
      endcase
      push_result(status, '0, 1'b0, 1'b1);
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] seen, longint unsigned stamp);
      if (seen !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", stamp, name, want, seen);
      end
    endfunction

    function void check_word(list_result_t got, longint unsigned stamp);
      list_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected, actual status %0d element %0d length %0d",
                 stamp, got.status, got.element, got.length);
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status, stamp);
      compare_field("element", want.element, got.element, stamp);
      compare_field("element_valid", want.element_valid, got.element_valid, stamp);
      compare_field("length", want.length, got.length, stamp);
      compare_field("last", want.last, got.last, stamp);
    endfunction
  endclass

endpackage

// ===== bench/tb_positional_list_insert_delete.sv =====
// Top-level bench for positional_list_insert_delete: directed and random list
// operations under random source and sink stalls (the last random phase runs
// without them), checked against the list mirror. Depends on pli_pkg, pli_if, pli_list_mirror_pkg and the block.
module tb_positional_list_insert_delete;
  timeunit 1ns;
  timeprecision 1ps;

  import pli_pkg::*;
  import pli_list_mirror_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam int unsigned PHASE_WORDS  = 35;

  logic clk;
  logic rst_n;

  pli_in_if  in_ch ();
  pli_out_if out_ch ();

  positional_list_insert_delete #(.CAPACITY(CAPACITY_DEF)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_mirror  mirror;
  int unsigned send_idle   = 0;
  int unsigned recv_idle   = 0;
  int unsigned cycle_count = 0;
  bit          filling     = 1'b1;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin : result_monitor
    list_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status        = out_ch.status;
      got.element       = out_ch.element;
      got.element_valid = out_ch.element_valid;
      got.length        = out_ch.length;
      got.last          = out_ch.last;
      mirror.check_word(got, $time);
    end
  end

  task automatic send_word(input logic [MODE_W-1:0] mode, input logic signed [DATA_W-1:0] value,
                           input logic [POS_W-1:0] position);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.value    <= value;
    in_ch.position <= position;
    do @(posedge clk); while (!in_ch.ready);
    mirror.note_word(mode, value, position);
  endtask

  // Hold the source off until every predicted result word has arrived.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
  endtask

  // Fill toward capacity, then drain toward empty, with mostly legal positions.
  task automatic send_random_word();
    int unsigned              len;
    int unsigned              pick;
    int unsigned              sub;
    bit                       want_insert;
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    len = mirror.count();
    if (len >= CAPACITY_DEF) filling = 1'b0;
    else if (len == 0) filling = 1'b1;
    pick        = $urandom_range(99);
    sub         = $urandom_range(2);
    want_insert = filling ? (pick < 84) : (pick < 28);
    // push against the rejected side now and then
    if ((len == 0 || len >= CAPACITY_DEF) && $urandom_range(2) == 0) want_insert = !want_insert;
    if (pick < 8) begin
      mode = MODE_DUMP;
    end else if (pick < 14) begin
      mode = MODE_COUNT;
    end else if (want_insert) begin
      mode = (sub == 0) ? MODE_INS_FIRST : (sub == 1) ? MODE_INS_LAST : MODE_INS_POS;
    end else begin
      mode = (sub == 0) ? MODE_DEL_FIRST : (sub == 1) ? MODE_DEL_LAST : MODE_DEL_POS;
    end
    if ($urandom_range(9) < 8) begin
      position = POS_W'(want_insert ? $urandom_range(len + 1, 1) : $urandom_range(len, 1));
    end else begin
      position = POS_W'($urandom_range(63));
    end
    case ($urandom_range(9))
      0: value = 32'sh8000_0000;
      1: value = 32'sh7fff_ffff;
      2: value = -32'sd1;
      3: value = 32'sd0;
      default: value = $urandom;
    endcase
    send_word(mode, value, position);
  endtask

  initial begin
    mirror         = new(CAPACITY_DEF);
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_COUNT;
    in_ch.value    = '0;
    in_ch.position = '0;
    repeat (9) @(posedge clk);
    rst_n     <= 1'b1;
    send_idle <= 30;
    recv_idle <= 45;
    @(posedge clk);

    // empty list corners
    send_word(MODE_DUMP, 32'sd0, 6'd0);
    send_word(MODE_COUNT, 32'sd0, 6'd0);
    send_word(MODE_DEL_FIRST, 32'sd0, 6'd0);
    send_word(MODE_DEL_LAST, 32'sd0, 6'd0);
    send_word(MODE_DEL_POS, 32'sd0, 6'd1);
    send_word(MODE_INS_POS, 32'sd5, 6'd0);
    send_word(MODE_INS_POS, 32'sd5, 6'd2);
    // build a short list with extreme values
    send_word(MODE_INS_POS, 32'sh8000_0000, 6'd1);
    send_word(MODE_INS_FIRST, 32'sh7fff_ffff, 6'd0);
    send_word(MODE_INS_LAST, -32'sd1, 6'd63);
    send_word(MODE_INS_POS, 32'sd7, 6'd63);
    send_word(MODE_INS_POS, 32'sd0, 6'd4);
    send_word(MODE_INS_POS, 32'sh5555_5555, 6'd2);
    send_word(MODE_DUMP, 32'sd0, 6'd0);
    // delete edges
    send_word(MODE_DEL_POS, 32'sd0, 6'd0);
    send_word(MODE_DEL_POS, 32'sd0, 6'd6);
    send_word(MODE_DEL_POS, 32'sd0, 6'd63);
    send_word(MODE_DEL_POS, 32'sd0, 6'd3);
    send_word(MODE_DEL_LAST, 32'sd0, 6'd0);
    send_word(MODE_DEL_FIRST, 32'sd0, 6'd0);
    send_word(MODE_COUNT, -32'sd1, 6'd63);
    send_word(MODE_DUMP, 32'sd0, 6'd0);
    send_word(MODE_DEL_POS, 32'sd0, 6'd2);
    send_word(MODE_DEL_POS, 32'sd0, 6'd1);
    send_word(MODE_DUMP, 32'sd0, 6'd0);

    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      send_idle <= (phase == 0) ? 30 : (phase == 1) ? 45 : 0;
      recv_idle <= (phase == 0) ? 45 : (phase == 1) ? 30 : 0;
      @(posedge clk);
      repeat (PHASE_WORDS) send_random_word();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pli_pkg.sv
rtl/pli_if.sv
rtl/pli_cell.sv
rtl/pli_ctrl.sv
rtl/positional_list_insert_delete.sv
rtl/pli_checker.sv
bench/pli_list_mirror_pkg.sv
bench/tb_positional_list_insert_delete.sv
